FILE: sv/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA RMC field extractor package
// Shared types and character constants for the RMC sentence parser.
// ----------------------------------------------------------------------------
package nrmc_pkg;

   localparam int MAX_FIELD_CHARS_DEFAULT = 16;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_R      = 8'h52;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_C      = 8'h43;
   localparam logic [7:0] CHAR_A      = 8'h41;

   // Header offset after the '$' and the last header byte.
   localparam logic [2:0] HDR_FIRST = 3'd1;
   localparam logic [2:0] HDR_R     = 3'd3;
   localparam logic [2:0] HDR_M     = 3'd4;
   localparam logic [2:0] HDR_C     = 3'd5;
   localparam logic [2:0] HDR_DONE  = 3'd6;

   // Field numbers counted by commas after the header.
   localparam logic [3:0] FIELD_TIME   = 4'd1;
   localparam logic [3:0] FIELD_STATUS = 4'd2;
   localparam logic [3:0] FIELD_LAT    = 4'd3;
   localparam logic [3:0] FIELD_LON    = 4'd5;
   localparam logic [3:0] FIELD_DATE   = 4'd9;

   // Time and date fields are cut to this many characters.
   localparam int SHORT_FIELD_CHARS = 6;

   typedef enum logic [2:0] {
      KIND_TIME   = 3'd0,
      KIND_STATUS = 3'd1,
      KIND_LAT    = 3'd2,
      KIND_LON    = 3'd3,
      KIND_DATE   = 3'd4,
      KIND_END    = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_value;
      logic [3:0] char_pos;
      logic       fix_valid;
   } result_type;

endpackage

FILE: sv/nmea_rmc_field_extractor.sv
// ----------------------------------------------------------------------------
// NMEA RMC field extractor
// Picks the time, status, position and date characters out of RMC sentences.
// ----------------------------------------------------------------------------
// The req_ channel carries one received byte per word. The rsp_ channel
// returns tagged characters: kind tells the field, char_pos the place of the
// character in it, and a sentence-end word carries fix_valid.
// Most bytes (header, unused fields, commas but the last) make no result word.
// A byte is held in an input register; the parser logic behind it decides
// the result, which is loaded into the result register when that register
// has room and then appears on rsp_valid.
// One byte is accepted every cycle unless a stall holds one back as below;
// the parser step between the input and result registers is combinational.
// If the receiver stalls with a word waiting, the next byte that produces a
// result waits in the input register and req_ready drops; bytes that give no
// result keep flowing.
// Synchronous reset empties both registers and returns the parser to idle,
// waiting for a '$'.
// ----------------------------------------------------------------------------
module nmea_rmc_field_extractor #(
   parameter int MAX_FIELD_CHARS = nrmc_pkg::MAX_FIELD_CHARS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_char_value,
   output logic [3:0] rsp_char_pos,
   output logic       rsp_fix_valid
);

   logic                 out_free;
   logic                 res_load;
   nrmc_pkg::result_type res;
   nrmc_pkg::result_type rsp_data;

   nrmc_parser #(
      .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .out_free    (out_free),
      .res_load    (res_load),
      .res         (res)
   );

   nrmc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_load  (res_load),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind       = rsp_data.kind;
   assign rsp_char_value = rsp_data.char_value;
   assign rsp_char_pos   = rsp_data.char_pos;
   assign rsp_fix_valid  = rsp_data.fix_valid;

endmodule

FILE: sv/nrmc_parser.sv
// ----------------------------------------------------------------------------
// NMEA RMC parser stage
// Holds the received byte in an input register, tracks the sentence state and
// decides the tagged character, if any, that the byte produces.
// ----------------------------------------------------------------------------
module nrmc_parser #(
   parameter int MAX_FIELD_CHARS = nrmc_pkg::MAX_FIELD_CHARS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic                 out_free,
   output logic                 res_load,
   output nrmc_pkg::result_type res
);

   localparam int CW = $clog2(MAX_FIELD_CHARS + 1);
   localparam logic [CW-1:0] MaxCount   = CW'(MAX_FIELD_CHARS);
   localparam logic [CW-1:0] ShortCount = CW'(nrmc_pkg::SHORT_FIELD_CHARS);

   logic          byte_valid_ff;
   logic [7:0]    byte_ff;

   logic          in_sentence_ff, in_sentence_in;
   logic [2:0]    header_pos_ff, header_pos_in;
   logic [3:0]    field_index_ff, field_index_in;
   logic [CW-1:0] count_ff, count_in;
   logic          status_is_a_ff, status_is_a_in;

   logic          has_result;
   logic          advance;
   logic          header_ok;

   // The held word moves on when it produces nothing or the result register
   // has room for it.
   assign advance   = byte_valid_ff && (!has_result || out_free);
   assign req_ready = !byte_valid_ff || advance;
   assign res_load  = advance && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (req_ready) begin
         byte_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         header_pos_ff  <= '0;
         field_index_ff <= '0;
         count_ff       <= '0;
         status_is_a_ff <= 1'b0;
      end else if (advance) begin
         in_sentence_ff <= in_sentence_in;
         header_pos_ff  <= header_pos_in;
         field_index_ff <= field_index_in;
         count_ff       <= count_in;
         status_is_a_ff <= status_is_a_in;
      end
   end

   always_comb begin
      case (header_pos_ff)
         nrmc_pkg::HDR_R: header_ok = (byte_ff == nrmc_pkg::CHAR_R);
         nrmc_pkg::HDR_M: header_ok = (byte_ff == nrmc_pkg::CHAR_M);
         nrmc_pkg::HDR_C: header_ok = (byte_ff == nrmc_pkg::CHAR_C);
         default:         header_ok = 1'b1;
      endcase
   end

   always_comb begin
      in_sentence_in = in_sentence_ff;
      header_pos_in  = header_pos_ff;
      field_index_in = field_index_ff;
      count_in       = count_ff;
      status_is_a_in = status_is_a_ff;
      has_result     = 1'b0;
      res.kind       = nrmc_pkg::KIND_TIME;
      res.char_value = byte_ff;
      res.char_pos   = count_ff[3:0];
      res.fix_valid  = 1'b0;

      if (byte_ff == nrmc_pkg::CHAR_DOLLAR) begin
         in_sentence_in = 1'b1;
         header_pos_in  = nrmc_pkg::HDR_FIRST;
         field_index_in = '0;
         count_in       = '0;
         status_is_a_in = 1'b0;
      end else if (!in_sentence_ff) begin
         // Bytes outside a sentence are dropped.
      end else if (header_pos_ff < nrmc_pkg::HDR_DONE) begin
         if (header_ok) begin
            header_pos_in = header_pos_ff + 3'd1;
         end else begin
            in_sentence_in = 1'b0;
            header_pos_in  = '0;
            field_index_in = '0;
            count_in       = '0;
            status_is_a_in = 1'b0;
         end
      end else if (byte_ff == nrmc_pkg::CHAR_COMMA) begin
         if (field_index_ff == nrmc_pkg::FIELD_DATE) begin
            has_result     = 1'b1;
            res.kind       = nrmc_pkg::KIND_END;
            res.char_value = '0;
            res.char_pos   = '0;
            res.fix_valid  = status_is_a_ff;
            in_sentence_in = 1'b0;
            header_pos_in  = '0;
            field_index_in = '0;
            count_in       = '0;
            status_is_a_in = 1'b0;
         end else begin
            field_index_in = field_index_ff + 4'd1;
            count_in       = '0;
         end
      end else begin
         case (field_index_ff)
            nrmc_pkg::FIELD_TIME: begin
               has_result = (count_ff < ShortCount);
               res.kind   = nrmc_pkg::KIND_TIME;
            end
            nrmc_pkg::FIELD_STATUS: begin
               has_result = (count_ff == '0);
               res.kind   = nrmc_pkg::KIND_STATUS;
               if (count_ff == '0) begin
                  status_is_a_in = (byte_ff == nrmc_pkg::CHAR_A);
               end
            end
            nrmc_pkg::FIELD_LAT: begin
               has_result = (count_ff < MaxCount);
               res.kind   = nrmc_pkg::KIND_LAT;
            end
            nrmc_pkg::FIELD_LON: begin
               has_result = (count_ff < MaxCount);
               res.kind   = nrmc_pkg::KIND_LON;
            end
            nrmc_pkg::FIELD_DATE: begin
               has_result = (count_ff < ShortCount);
               res.kind   = nrmc_pkg::KIND_DATE;
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
         if (count_ff < MaxCount) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !in_sentence_ff |-> (header_pos_ff == '0) && (field_index_ff == '0))
      else $error("idle parser holds stale header or field state");

   a_header_range: assert property (@(posedge clock) disable iff (reset)
      header_pos_ff <= nrmc_pkg::HDR_DONE)
      else $error("header position past end of header");

   a_field_range: assert property (@(posedge clock) disable iff (reset)
      field_index_ff <= nrmc_pkg::FIELD_DATE)
      else $error("field index past the date field");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount)
      else $error("field character count past saturation");

   a_fields_after_header: assert property (@(posedge clock) disable iff (reset)
      (field_index_ff != '0) |-> (header_pos_ff == nrmc_pkg::HDR_DONE))
      else $error("field counted before header complete");

endmodule

FILE: sv/nrmc_rsp_reg.sv
// ----------------------------------------------------------------------------
// NMEA RMC result register
// Holds one tagged character until the receiver takes it.
// ----------------------------------------------------------------------------
module nrmc_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_load,
   input  nrmc_pkg::result_type res,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nrmc_pkg::result_type rsp_data
);

   logic                 valid_ff;
   nrmc_pkg::result_type data_ff;

   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         data_ff <= res;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |-> !res_load)
      else $error("result register loaded while holding an untaken word");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff.kind == nrmc_pkg::KIND_END) |->
         (data_ff.char_value == '0) && (data_ff.char_pos == '0))
      else $error("end marker carries character data");

   a_fix_only_end: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff.fix_valid) |-> (data_ff.kind == nrmc_pkg::KIND_END))
      else $error("fix flag set on a character word");

endmodule
